// ----- sv/bmp24_to_rgb565_window_streamer_unit_assert.svh -----
// Assertion macros for the BMP streamer.
`ifndef BMP24_TO_RGB565_WINDOW_STREAMER_UNIT_ASSERT_SVH
`define BMP24_TO_RGB565_WINDOW_STREAMER_UNIT_ASSERT_SVH

// Check a property on the rising clock, suspended while reset is asserted.
`define B2R_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on the rising clock, also during reset.
`define B2R_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/b2r_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2r_pkg
// Shared types and constants of the BMP to RGB565 window streamer.
// ----------------------------------------------------------------------------
package b2r_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF    = 240;
  localparam int unsigned SCREEN_HEIGHT_DEF   = 320;
  localparam int unsigned MAX_IMAGE_WIDTH_DEF = 1280;

  localparam int unsigned COORD_W = 11;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned IW_W    = 14;
  localparam int unsigned COL_W   = 13;

  localparam logic [5:0] POS_OFFSET = 6'd10;
  localparam logic [5:0] POS_WIDTH  = 6'd18;
  localparam logic [5:0] POS_HEIGHT = 6'd22;
  localparam logic [5:0] POS_PLANES = 6'd26;
  localparam logic [5:0] POS_COMP   = 6'd30;
  localparam logic [5:0] POS_CHECK  = 6'd33;
  localparam logic [31:0] MIN_OFFSET = 32'd34;

  localparam logic CFG_COLUMN_OFFSET = 1'b0;
  localparam logic CFG_ROW_OFFSET    = 1'b1;

  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_WINDOW = 3'd1,
    KIND_PIXEL  = 3'd2,
    KIND_REJECT = 3'd3,
    KIND_DONE   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SEEK   = 2'd1,
    PH_ROWS   = 2'd2,
    PH_IDLE   = 2'd3
  } phase_e;

  typedef struct packed {
    kind_e        kind;
    logic [10:0]  x_first;
    logic [10:0]  x_last;
    logic [10:0]  screen_row;
    logic [15:0]  pixel;
  } res_t;

  // One queue entry: a result, and whether a done result follows it.
  typedef struct packed {
    res_t res;
    logic more;
  } entry_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
    logic       empty;
  } fifo_status_t;

  function automatic logic [31:0] put_byte(logic [31:0] word, logic [1:0] lane,
                                           logic [7:0] b);
    logic [31:0] w;
    w = word;
    w[lane*8 +: 8] = b;
    return w;
  endfunction

endpackage

// ----- sv/bmp24_to_rgb565_window_streamer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_to_rgb565_window_streamer_unit
// Streams a 24-bit BMP file in and RGB565 window and pixel requests out.
// ----------------------------------------------------------------------------
// Input channel: one file byte per request in s_axis_tdata_i, tlast on the
// final byte of the file. Output channel: results with their kind in tuser
// (clear, window, pixel, rejected, done) and tlast on the final result that
// one byte causes. A byte causes zero, one or two results.
// Configuration: cfg_we_i writes cfg_wdata_i to the column offset (index 0)
// or the row offset (index 1); write only while the block is idle.
// The result of an accepted byte is written into the queue and shown on the
// output from there. Throughput: one byte per cycle while the queue is not
// full, set by the parser's single update per byte; a byte that yields two
// results holds the output for both, and the two-entry queue absorbs that.
// Reset clears the parser to header parsing and empties the queue.
// When the receiver stalls, results wait in the queue; input is accepted
// until the queue is full, then s_axis_tready_o drops.
// ----------------------------------------------------------------------------
`include "bmp24_to_rgb565_window_streamer_unit_assert.svh"

module bmp24_to_rgb565_window_streamer_unit #(
  parameter int unsigned SCREEN_WIDTH    = b2r_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT   = b2r_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned MAX_IMAGE_WIDTH = b2r_pkg::MAX_IMAGE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // x_first, x_last, screen_row, pixel, zero fill
  output logic [2:0]  m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o
);

  logic                  push, pop;
  b2r_pkg::entry_t       push_entry, head;
  b2r_pkg::fifo_status_t fst;
  b2r_pkg::res_t         res;

  b2r_front #(
    .SCREEN_WIDTH   (SCREEN_WIDTH),
    .SCREEN_HEIGHT  (SCREEN_HEIGHT),
    .MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_end_i    (s_axis_tlast_i),
    .fifo_full_i (fst.full),
    .push_o      (push),
    .push_entry_o(push_entry)
  );

  b2r_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (fst)
  );

  b2r_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (fst.empty),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_res_o  (res),
    .out_last_o (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = res.kind;
  assign m_axis_tdata_o = {7'd0, res.pixel, res.screen_row, res.x_last, res.x_first};

  `B2R_ASSERT(a_fifo_bound, fst.count != 2'd3, "queue count out of range")
  `B2R_ASSERT(a_ready_full, !s_axis_tready_o |-> fst.count == 2'd2,
              "input stalled with room in queue")
  `B2R_ASSERT(a_done_last,
              m_axis_tvalid_o && m_axis_tuser_o == b2r_pkg::KIND_DONE |-> m_axis_tlast_o,
              "done result without tlast")

endmodule

// ----- sv/b2r_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2r_front
// Header parser and row walker: turns each file byte that causes a result into a queue entry.
// ----------------------------------------------------------------------------
module b2r_front #(
  parameter int unsigned SCREEN_WIDTH    = b2r_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT   = b2r_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned MAX_IMAGE_WIDTH = b2r_pkg::MAX_IMAGE_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [9:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_end_i,
  input  logic                 fifo_full_i,
  output logic                 push_o,
  output b2r_pkg::entry_t      push_entry_o
);

  localparam logic [10:0] SW  = 11'(SCREEN_WIDTH);
  localparam logic [31:0] SH  = 32'(SCREEN_HEIGHT);
  localparam logic [31:0] MW  = 32'(MAX_IMAGE_WIDTH);

  b2r_pkg::phase_e phase_q, phase_d;
  logic [31:0] pos_q, pos_d, off_q, off_d, width_q, width_d, height_q, height_d;
  logic [31:0] planes_q, planes_d, comp_q, comp_d, skip_q, skip_d;
  logic [13:0] bir_q, bir_d, iw_q, iw_d;
  logic [1:0]  k_q, k_d;
  logic [12:0] col_q, col_d, shown_q, shown_d;
  logic [10:0] row_q, row_d, xs_q, xs_d, xe_q, xe_d, ys_q, ys_d;
  logic [7:0]  blue_q, blue_d, green_q, green_d;
  logic [9:0]  colofs_q, rowofs_q;

  logic        accept, has_r, has_done, ok, row_end, do_pix;
  logic [31:0] comp_full;
  logic [12:0] w13;
  logic [10:0] h11;
  logic [13:0] bir_inc;
  logic [5:0]  p6;
  b2r_pkg::res_t r;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign p6         = pos_q[5:0];
  assign w13        = width_q[12:0];
  assign h11        = height_q[10:0];
  assign comp_full  = {in_byte_i, comp_q[23:0]};
  assign bir_inc    = bir_q + 14'd1;
  assign row_end    = bir_inc >= iw_q;
  assign do_pix     = (phase_q == b2r_pkg::PH_ROWS) ||
                      ((phase_q == b2r_pkg::PH_SEEK) && (pos_q == off_q));

  assign ok = (planes_q[15:0] == 16'd1) && (planes_q[31:16] == 16'd24) &&
              (comp_full == 32'd0) && (width_q != 32'd0) && (width_q <= MW) &&
              (height_q != 32'd0) && (off_q >= b2r_pkg::MIN_OFFSET);

  always_comb begin
    phase_d  = phase_q;  pos_d = pos_q;  off_d = off_q;  width_d = width_q;
    height_d = height_q; planes_d = planes_q; comp_d = comp_q; skip_d = skip_q;
    bir_d = bir_q; iw_d = iw_q; k_d = k_q; col_d = col_q; shown_d = shown_q;
    row_d = row_q; xs_d = xs_q; xe_d = xe_q; ys_d = ys_q;
    blue_d = blue_q; green_d = green_q;
    has_r = 1'b0;
    has_done = 1'b0;
    r = '0;
    if (accept) begin
      pos_d = pos_q + 32'd1;
      unique case (phase_q)
        b2r_pkg::PH_HEADER: begin
          if (p6 >= b2r_pkg::POS_OFFSET && p6 < b2r_pkg::POS_OFFSET + 6'd4) begin
            off_d = b2r_pkg::put_byte(off_q, 2'(p6 - b2r_pkg::POS_OFFSET), in_byte_i);
          end else if (p6 >= b2r_pkg::POS_WIDTH && p6 < b2r_pkg::POS_WIDTH + 6'd4) begin
            width_d = b2r_pkg::put_byte(width_q, 2'(p6 - b2r_pkg::POS_WIDTH), in_byte_i);
          end else if (p6 >= b2r_pkg::POS_HEIGHT && p6 < b2r_pkg::POS_HEIGHT + 6'd4) begin
            height_d = b2r_pkg::put_byte(height_q, 2'(p6 - b2r_pkg::POS_HEIGHT),
                                         in_byte_i);
          end else if (p6 >= b2r_pkg::POS_PLANES && p6 < b2r_pkg::POS_PLANES + 6'd4) begin
            planes_d = b2r_pkg::put_byte(planes_q, 2'(p6 - b2r_pkg::POS_PLANES),
                                         in_byte_i);
          end else if (p6 >= b2r_pkg::POS_COMP && p6 < b2r_pkg::POS_COMP + 6'd4) begin
            comp_d = b2r_pkg::put_byte(comp_q, 2'(p6 - b2r_pkg::POS_COMP), in_byte_i);
          end
          if (p6 == b2r_pkg::POS_CHECK) begin
            has_r = 1'b1;
            if (!ok) begin
              r.kind  = b2r_pkg::KIND_REJECT;
              phase_d = b2r_pkg::PH_IDLE;
            end else begin
              if (32'(w13) > 32'(SW)) begin
                xs_d    = 11'd0;
                xe_d    = SW - 11'd1;
                shown_d = 13'(SW);
              end else begin
                xs_d    = (SW - w13[10:0]) >> 1;
                xe_d    = ((SW - w13[10:0]) >> 1) + w13[10:0] - 11'd1;
                shown_d = w13;
              end
              if (height_q > SH) begin
                ys_d   = 11'd0;
                row_d  = 11'(SH - 32'd1);
                skip_d = height_q - SH;
              end else begin
                ys_d   = (11'(SH) - h11) >> 1;
                row_d  = ((11'(SH) - h11) >> 1) + h11 - 11'd1;
                skip_d = 32'd0;
              end
              iw_d = (14'({w13, 1'b0}) + 14'(w13) + 14'd3) & ~14'd3;
              bir_d = '0; k_d = '0; col_d = '0;
              r.kind       = b2r_pkg::KIND_CLEAR;
              r.x_first    = 11'(colofs_q);
              r.x_last     = 11'(colofs_q) + SW - 11'd1;
              r.screen_row = 11'(rowofs_q);
              phase_d      = b2r_pkg::PH_SEEK;
            end
          end
        end
        b2r_pkg::PH_SEEK, b2r_pkg::PH_ROWS: begin
          if (do_pix) begin
            phase_d = b2r_pkg::PH_ROWS;
            if (k_q == 2'd2) begin
              k_d   = 2'd0;
              col_d = col_q + 13'd1;
            end else begin
              k_d = k_q + 2'd1;
            end
            bir_d = bir_inc;
            if (skip_q != 32'd0) begin
              if (row_end) begin
                bir_d = '0; k_d = '0; col_d = '0;
                skip_d = skip_q - 32'd1;
              end
            end else begin
              if (bir_q == 14'd0) begin
                has_r        = 1'b1;
                r.kind       = b2r_pkg::KIND_WINDOW;
                r.x_first    = 11'(colofs_q) + xs_q;
                r.x_last     = 11'(colofs_q) + xe_q;
                r.screen_row = 11'(rowofs_q) + row_q;
              end
              case (k_q)
                2'd0: blue_d = in_byte_i;
                2'd1: green_d = in_byte_i;
                default: begin
                  if (col_q < shown_q) begin
                    has_r   = 1'b1;
                    r.kind  = b2r_pkg::KIND_PIXEL;
                    r.pixel = {in_byte_i[7:3], green_q[7:2], blue_q[7:3]};
                  end
                end
              endcase
              if (row_end) begin
                bir_d = '0; k_d = '0; col_d = '0;
                if (row_q == ys_q) begin
                  has_done = 1'b1;
                  phase_d  = b2r_pkg::PH_IDLE;
                end else begin
                  row_d = row_q - 11'd1;
                end
              end
            end
          end
        end
        default: ;
      endcase
      // return to header parsing after the final byte
      if (in_end_i) begin
        phase_d = b2r_pkg::PH_HEADER;
        pos_d = '0; skip_d = '0; bir_d = '0; k_d = '0; col_d = '0;
      end
    end
  end

  always_comb begin
    push_o = accept && (has_r || has_done);
    push_entry_o.res  = r;
    push_entry_o.more = has_r && has_done;
    if (!has_r) begin
      push_entry_o.res      = '0;
      push_entry_o.res.kind = b2r_pkg::KIND_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= b2r_pkg::PH_HEADER;
      pos_q <= '0; off_q <= '0; width_q <= '0; height_q <= '0;
      planes_q <= '0; comp_q <= '0; skip_q <= '0;
      bir_q <= '0; iw_q <= '0; k_q <= '0; col_q <= '0; shown_q <= '0;
      row_q <= '0; xs_q <= '0; xe_q <= '0; ys_q <= '0;
      blue_q <= '0; green_q <= '0;
      colofs_q <= '0; rowofs_q <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q <= pos_d; off_q <= off_d; width_q <= width_d; height_q <= height_d;
      planes_q <= planes_d; comp_q <= comp_d; skip_q <= skip_d;
      bir_q <= bir_d; iw_q <= iw_d; k_q <= k_d; col_q <= col_d; shown_q <= shown_d;
      row_q <= row_d; xs_q <= xs_d; xe_q <= xe_d; ys_q <= ys_d;
      blue_q <= blue_d; green_q <= green_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          b2r_pkg::CFG_COLUMN_OFFSET: colofs_q <= cfg_wdata_i;
          b2r_pkg::CFG_ROW_OFFSET:    rowofs_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- sv/b2r_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2r_fifo
// Two-entry queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module b2r_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  b2r_pkg::entry_t        push_entry_i,
  input  logic                   pop_i,
  output b2r_pkg::entry_t        head_o,
  output b2r_pkg::fifo_status_t  status_o
);

  b2r_pkg::entry_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q, count_d;

  assign head_o          = mem_q[rd_q];
  assign status_o.count  = count_q;
  assign status_o.full   = count_q == 2'd2;
  assign status_o.empty  = count_q == 2'd0;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 2'd1;
    if (pop_i && !push_i) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      count_q <= count_d;
    end
  end

endmodule

// ----- sv/b2r_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2r_back
// Output stage: sends the queued result, then a trailing done result when the entry asks for one.
// ----------------------------------------------------------------------------
module b2r_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  b2r_pkg::entry_t        head_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output b2r_pkg::res_t          out_res_o,
  output logic                   out_last_o
);

  logic sub_q, fire;

  assign out_valid_o = !empty_i;
  assign fire        = out_valid_o && out_ready_i;
  assign pop_o       = fire && (sub_q || !head_i.more);
  assign out_last_o  = sub_q || !head_i.more;

  always_comb begin
    out_res_o = head_i.res;
    if (sub_q) begin
      out_res_o      = '0;
      out_res_o.kind = b2r_pkg::KIND_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else if (fire) begin
      sub_q <= !pop_o;
    end
  end

endmodule

// ----- test/bmp_stream_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_stream_checker
// Watches the byte, result and register ports of the BMP streamer. It keeps
// its own parser state, computes the requests each accepted byte must cause,
// and compares every accepted result request with the oldest one expected.
// ----------------------------------------------------------------------------
module bmp_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [55:0] m_tdata_i,   // x_first, x_last, screen_row, pixel, zero fill
  input  logic [2:0]  m_tuser_i,   // kind
  input  logic        m_tlast_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_seen_o
);

  localparam logic [31:0] SCR_W = b2r_pkg::SCREEN_WIDTH_DEF;
  localparam logic [31:0] SCR_H = b2r_pkg::SCREEN_HEIGHT_DEF;
  localparam logic [31:0] MAX_W = b2r_pkg::MAX_IMAGE_WIDTH_DEF;

  typedef struct {
    b2r_pkg::kind_e kind;
    logic [10:0]    x_first;
    logic [10:0]    x_last;
    logic [10:0]    row;
    logic [15:0]    pixel;
    logic           last;
  } draw_req_t;

  draw_req_t       draw_q[$];
  logic [9:0]      col_off, row_off;
  b2r_pkg::phase_e ph;
  logic [31:0] pos, pix_off, img_w, img_h, planes_bpp, comp, skip_rows, row_byte,
               cur_row, xs, xe, ys, ye, colour;

  task automatic clear_parser();
    ph = b2r_pkg::PH_HEADER;
    pos = 0; pix_off = 0; img_w = 0; img_h = 0; planes_bpp = 0; comp = 0;
    skip_rows = 0; row_byte = 0; cur_row = 0; xs = 0; xe = 0; ys = 0; ye = 0;
    colour = 0;
  endtask

  task automatic push_req(b2r_pkg::kind_e k, logic [31:0] xf, logic [31:0] xl,
                          logic [31:0] r, logic [31:0] pix);
    draw_req_t e;
    e.kind = k; e.x_first = xf[10:0]; e.x_last = xl[10:0]; e.row = r[10:0];
    e.pixel = pix[15:0]; e.last = 1'b0;
    draw_q.push_back(e);
  endtask

  task automatic parse_header(logic [31:0] b);
    logic ok;
    if (pos >= 10 && pos <= 13) pix_off |= b << (8 * (pos - 10));
    else if (pos >= 18 && pos <= 21) img_w |= b << (8 * (pos - 18));
    else if (pos >= 22 && pos <= 25) img_h |= b << (8 * (pos - 22));
    else if (pos >= 26 && pos <= 29) planes_bpp |= b << (8 * (pos - 26));
    else if (pos >= 30 && pos <= 33) comp |= b << (8 * (pos - 30));
    if (pos != 33) return;
    ok = planes_bpp[15:0] == 16'd1 && planes_bpp[31:16] == 16'd24 && comp == 0 &&
         img_w != 0 && img_w <= MAX_W && img_h != 0 && pix_off >= 34;
    if (!ok) begin
      push_req(b2r_pkg::KIND_REJECT, 0, 0, 0, 0);
      ph = b2r_pkg::PH_IDLE;
      return;
    end
    if (img_w > SCR_W) begin
      xs = 0; xe = SCR_W - 1;
    end else begin
      xs = (SCR_W - img_w) / 2; xe = xs + img_w - 1;
    end
    if (img_h > SCR_H) begin
      ys = 0; ye = SCR_H - 1; skip_rows = img_h - SCR_H;
    end else begin
      ys = (SCR_H - img_h) / 2; ye = ys + img_h - 1; skip_rows = 0;
    end
    cur_row = ye; row_byte = 0; colour = 0;
    push_req(b2r_pkg::KIND_CLEAR, 32'(col_off), 32'(col_off) + SCR_W - 1,
             32'(row_off), 0);
    ph = b2r_pkg::PH_SEEK;
  endtask

  task automatic pixel_data(logic [31:0] b);
    logic [31:0] stride, shown, lane, pix;
    stride = ((img_w * 3) + 3) & ~32'd3;
    shown = img_w > SCR_W ? SCR_W : img_w;
    lane = row_byte % 3;
    if (skip_rows != 0) begin
      row_byte++;
      if (row_byte >= stride) begin
        row_byte = 0;
        skip_rows--;
      end
      return;
    end
    if (row_byte == 0)
      push_req(b2r_pkg::KIND_WINDOW, 32'(col_off) + xs, 32'(col_off) + xe,
               32'(row_off) + cur_row, 0);
    if (lane == 0) begin
      colour = (colour & 32'hFF00) | b;
    end else if (lane == 1) begin
      colour = (colour & 32'h00FF) | (b << 8);
    end else if (row_byte / 3 < shown) begin
      pix = (colour[7:0] >> 3) | ((colour[15:8] >> 2) << 5) | ((b >> 3) << 11);
      push_req(b2r_pkg::KIND_PIXEL, 0, 0, 0, pix);
    end
    row_byte++;
    if (row_byte >= stride) begin
      row_byte = 0;
      if (cur_row == ys) begin
        push_req(b2r_pkg::KIND_DONE, 0, 0, 0, 0);
        ph = b2r_pkg::PH_IDLE;
      end else begin
        cur_row--;
      end
    end
  endtask

  task automatic predict_byte(logic [7:0] b, logic file_end);
    int n_prior;
    n_prior = draw_q.size();
    case (ph)
      b2r_pkg::PH_HEADER: parse_header({24'd0, b});
      b2r_pkg::PH_SEEK: begin
        if (pos == pix_off) begin
          ph = b2r_pkg::PH_ROWS;
          pixel_data({24'd0, b});
        end
      end
      b2r_pkg::PH_ROWS: pixel_data({24'd0, b});
      default: ;
    endcase
    pos++;
    if (draw_q.size() > n_prior) draw_q[draw_q.size() - 1].last = 1'b1;
    if (file_end) clear_parser();
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    draw_req_t w;
    if (!rst_ni) begin
      col_off = '0;
      row_off = '0;
      clear_parser();
      draw_q.delete();
      fail_count_o = 0;
      results_seen_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == b2r_pkg::CFG_COLUMN_OFFSET) col_off = cfg_wdata_i;
        else row_off = cfg_wdata_i;
      end
      if (s_tvalid_i && s_tready_i) predict_byte(s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) begin
        results_seen_o++;
        if (draw_q.size() == 0) begin
          report("unexpected result, kind", {29'd0, m_tuser_i}, 0);
        end else begin
          w = draw_q.pop_front();
          if (m_tuser_i != w.kind) report("kind", {29'd0, m_tuser_i}, {29'd0, w.kind});
          if (m_tdata_i[10:0] != w.x_first)
            report("x_first", 32'(m_tdata_i[10:0]), 32'(w.x_first));
          if (m_tdata_i[21:11] != w.x_last)
            report("x_last", 32'(m_tdata_i[21:11]), 32'(w.x_last));
          if (m_tdata_i[32:22] != w.row)
            report("screen_row", 32'(m_tdata_i[32:22]), 32'(w.row));
          if (m_tdata_i[48:33] != w.pixel)
            report("pixel", 32'(m_tdata_i[48:33]), 32'(w.pixel));
          if (m_tdata_i[55:49] != 7'd0) report("zero fill", 32'(m_tdata_i[55:49]), 0);
          if (m_tlast_i != w.last) report("tlast", 32'(m_tlast_i), 32'(w.last));
        end
      end
      pending_o = draw_q.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams directed and random BMP files through the streamer with bursty
// input, a stalling receiver and offset changes between files.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = b2r_pkg::CFG_COLUMN_OFFSET;
  logic [9:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;   // x_first, x_last, screen_row, pixel, zero fill
  logic [2:0]  m_tuser;   // kind
  logic        m_tlast;
  logic        byte_taken = 1'b0;
  int          fail_count, pending, results_seen;
  int          cycles = 0, bytes_sent = 0, files_sent = 0, burst_left = 0;
  int          stall_mode = 0, stall_left = 0;
  logic [7:0]  file_q[$];

  always #6 clk_i = ~clk_i;

  bmp24_to_rgb565_window_streamer_unit dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tlast_i(s_tlast),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser), .m_axis_tlast_o(m_tlast)
  );

  bmp_stream_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .s_tlast_i(s_tlast), .m_tvalid_i(m_tvalid), .m_tready_i(m_tready),
    .m_tdata_i(m_tdata), .m_tuser_i(m_tuser), .m_tlast_i(m_tlast),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  always @(posedge clk_i) begin
    byte_taken <= s_tvalid && s_tready;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: switch between free flow, random stalls and long stalls.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_byte(logic [7:0] b, logic file_end);
    if (burst_left == 0) begin
      if ($urandom_range(0, 1)) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= file_end;
    do @(negedge clk_i); while (!byte_taken);
    bytes_sent++;
  endtask

  // Drop valid for one cycle after the file.
  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    files_sent++;
  endtask

  // Header plus pixel data; keep caps the length for short files.
  task automatic build_file(logic [31:0] offset, logic [31:0] w, logic [31:0] h,
                            logic [15:0] planes, logic [15:0] bpp, logic [31:0] comp,
                            int keep);
    int hdr_len, data_len, total;
    logic [31:0] stride;
    stride = ((w * 3) + 3) & ~32'd3;
    hdr_len = (offset >= 34 && offset < 200) ? offset : 34 + $urandom_range(0, 4);
    data_len = (w <= b2r_pkg::MAX_IMAGE_WIDTH_DEF && h <= 2000) ? stride * h : 0;
    total = hdr_len + data_len + $urandom_range(0, 3);
    if (keep > 0 && keep < total) total = keep;
    file_q.delete();
    for (int i = 0; i < total; i++) file_q.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < 4; i++) begin
      if (10 + i < total) file_q[10 + i] = offset[8*i +: 8];
      if (18 + i < total) file_q[18 + i] = w[8*i +: 8];
      if (22 + i < total) file_q[22 + i] = h[8*i +: 8];
      if (30 + i < total) file_q[30 + i] = comp[8*i +: 8];
    end
    for (int i = 0; i < 2; i++) begin
      if (26 + i < total) file_q[26 + i] = planes[8*i +: 8];
      if (28 + i < total) file_q[28 + i] = bpp[8*i +: 8];
    end
  endtask

  task automatic good_file(logic [31:0] offset, logic [31:0] w, logic [31:0] h);
    build_file(offset, w, h, 16'd1, 16'd24, 32'd0, 0);
    send_file();
  endtask

  // Write one offset register once every expected request has come out.
  task automatic write_offset(logic idx, logic [9:0] val);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int wait_cycles, pick;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_offset(b2r_pkg::CFG_COLUMN_OFFSET, 10'd0);
    write_offset(b2r_pkg::CFG_ROW_OFFSET, 10'd0);
    good_file(34, 1, 1);
    good_file(54, 3, 2);
    write_offset(b2r_pkg::CFG_COLUMN_OFFSET, 10'h3FF);
    write_offset(b2r_pkg::CFG_ROW_OFFSET, 10'h3FF);
    good_file(40, 7, 2);
    // tall image: skip one bottom row, then draw until cut short
    build_file(34, 1, 321, 16'd1, 16'd24, 32'd0, 80);
    send_file();
    // top-down file: huge height, cut short while rows are still skipped
    build_file(54, 2, 32'hFFFF_FFF0, 16'd1, 16'd24, 32'd0, 100);
    send_file();
    build_file(54, 4, 3, 16'd1, 16'd24, 32'd0, 60);   // ends before done
    send_file();
    build_file(54, 4, 3, 16'd2, 16'd24, 32'd0, 36);   // bad planes
    send_file();
    build_file(54, 4, 3, 16'd1, 16'd32, 32'd0, 36);   // bad bit count
    send_file();
    build_file(54, 4, 3, 16'd1, 16'd24, 32'd1, 36);   // compressed
    send_file();
    build_file(54, 0, 3, 16'd1, 16'd24, 32'd0, 36);   // zero width
    send_file();
    build_file(54, 1281, 3, 16'd1, 16'd24, 32'd0, 36); // too wide
    send_file();
    build_file(54, 4, 0, 16'd1, 16'd24, 32'd0, 36);   // zero height
    send_file();
    build_file(33, 4, 3, 16'd1, 16'd24, 32'd0, 36);   // offset too small
    send_file();

    while (bytes_sent < 800) begin
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 5) == 0)
        write_offset(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
      if (pick < 7) begin
        good_file($urandom_range(34, 60), $urandom_range(1, 12), $urandom_range(1, 6));
      end else if (pick == 7) begin
        build_file($urandom_range(34, 60), $urandom_range(1, 12), $urandom_range(1, 6),
                   16'd1, 16'd24, 32'd0, $urandom_range(1, 90));
        send_file();
      end else if (pick == 8) begin
        build_file($urandom_range(0, 60), $urandom_range(0, 1300), $urandom_range(0, 3),
                   16'($urandom_range(0, 2)), 16'($urandom_range(23, 25)),
                   $urandom_range(0, 1), 50);
        send_file();
      end else begin
        file_q.delete();
        repeat ($urandom_range(1, 40)) file_q.push_back(8'($urandom_range(0, 255)));
        send_file();
      end
    end

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(negedge clk_i);
    $display("Sent %0d files, %0d bytes; %0d result requests checked",
             files_sent, bytes_sent, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors, %0d requests never arrived", fail_count, pending);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/b2r_pkg.sv
sv/b2r_front.sv
sv/b2r_fifo.sv
sv/b2r_back.sv
sv/bmp24_to_rgb565_window_streamer_unit.sv
test/bmp_stream_checker.sv
test/tb_top.sv
